@@ src/slns_pkg.sv @@
// Shared constants, kind codes and queue entry type for the Lambert shading core.
`default_nettype none
package slns_pkg;

  localparam int CW = 24;   // input component width
  localparam int RW = 16;   // component width after range reduction
  localparam int NCW = 49;  // cylinder normal width before reduction

  localparam logic [2:0] KIND_SPHERE = 3'd0;
  localparam logic [2:0] KIND_PLANE  = 3'd1;
  localparam logic [2:0] KIND_CYL    = 3'd2;
  localparam logic [2:0] KIND_TOP    = 3'd3;
  localparam logic [2:0] KIND_BOTTOM = 3'd4;

  // request handed from the front to the back through the queue
  typedef struct packed {
    logic [31:0] ll;    // |L|^2
    logic [31:0] nn;    // |N|^2
    logic [31:0] dmag;  // L.N when positive, else zero
    logic        zero;  // force intensity to zero
    logic        degen; // zero-length normal or light
  } entry_t;

endpackage
`default_nettype wire

@@ src/slns_front.sv @@
// Front pipeline: range reduction, normal formation and dot products.
`default_nettype none
module slns_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [2:0]                        in_kind,
  input  wire logic signed [slns_pkg::CW-1:0]    in_rel_x,
  input  wire logic signed [slns_pkg::CW-1:0]    in_rel_y,
  input  wire logic signed [slns_pkg::CW-1:0]    in_rel_z,
  input  wire logic signed [slns_pkg::CW-1:0]    in_axis_x,
  input  wire logic signed [slns_pkg::CW-1:0]    in_axis_y,
  input  wire logic signed [slns_pkg::CW-1:0]    in_axis_z,
  input  wire logic signed [slns_pkg::CW-1:0]    in_light_x,
  input  wire logic signed [slns_pkg::CW-1:0]    in_light_y,
  input  wire logic signed [slns_pkg::CW-1:0]    in_light_z,
  output logic                                   push,
  output slns_pkg::entry_t                       push_data,
  input  wire logic                              q_full
);

  // shift that brings all three components into RW signed bits
  function automatic logic [3:0] shamt_in(input logic signed [slns_pkg::CW-1:0] x,
                                          input logic signed [slns_pkg::CW-1:0] y,
                                          input logic signed [slns_pkg::CW-1:0] z);
    logic [slns_pkg::CW-2:0] o;
    logic [3:0] k;
    o = (x[slns_pkg::CW-1] ? ~x[slns_pkg::CW-2:0] : x[slns_pkg::CW-2:0]) |
        (y[slns_pkg::CW-1] ? ~y[slns_pkg::CW-2:0] : y[slns_pkg::CW-2:0]) |
        (z[slns_pkg::CW-1] ? ~z[slns_pkg::CW-2:0] : z[slns_pkg::CW-2:0]);
    k = '0;
    for (int i = slns_pkg::RW - 1; i < slns_pkg::CW - 1; i++) begin
      if (o[i]) k = 4'(i - slns_pkg::RW + 2);
    end
    return k;
  endfunction

  function automatic logic signed [slns_pkg::RW-1:0] red_in(
      input logic signed [slns_pkg::CW-1:0] x, input logic [3:0] k);
    logic signed [slns_pkg::CW-1:0] t;
    t = x >>> k;
    return t[slns_pkg::RW-1:0];
  endfunction

  function automatic logic [5:0] shamt_nc(input logic signed [slns_pkg::NCW-1:0] x,
                                          input logic signed [slns_pkg::NCW-1:0] y,
                                          input logic signed [slns_pkg::NCW-1:0] z);
    logic [slns_pkg::NCW-2:0] o;
    logic [5:0] k;
    o = (x[slns_pkg::NCW-1] ? ~x[slns_pkg::NCW-2:0] : x[slns_pkg::NCW-2:0]) |
        (y[slns_pkg::NCW-1] ? ~y[slns_pkg::NCW-2:0] : y[slns_pkg::NCW-2:0]) |
        (z[slns_pkg::NCW-1] ? ~z[slns_pkg::NCW-2:0] : z[slns_pkg::NCW-2:0]);
    k = '0;
    for (int i = slns_pkg::RW - 1; i < slns_pkg::NCW - 1; i++) begin
      if (o[i]) k = 6'(i - slns_pkg::RW + 2);
    end
    return k;
  endfunction

  function automatic logic signed [slns_pkg::RW-1:0] red_nc(
      input logic signed [slns_pkg::NCW-1:0] x, input logic [5:0] k);
    logic signed [slns_pkg::NCW-1:0] t;
    t = x >>> k;
    return t[slns_pkg::RW-1:0];
  endfunction

  logic fe;

  logic                    f1_v_r, f2_v_r, f3_v_r, f4_v_r, f5_v_r, f6_v_r;
  logic [2:0]              f1_kind_r, f2_kind_r, f3_kind_r, f4_kind_r;
  logic signed [15:0]      f1_r_r [3], f2_r_r [3], f3_r_r [3], f4_r_r [3];
  logic signed [15:0]      f1_a_r [3], f2_a_r [3], f3_a_r [3], f4_a_r [3];
  logic signed [15:0]      f1_l_r [3], f2_l_r [3], f3_l_r [3], f4_l_r [3], f5_l_r [3];
  logic signed [32:0]      f2_aa_r, f2_ra_r;
  logic signed [48:0]      f3_pr_r [3], f3_pa_r [3];
  logic signed [48:0]      f4_nc_r [3];
  logic signed [16:0]      f5_n_r [3];
  logic [31:0]             f6_ll_r, f6_nn_r;
  logic signed [32:0]      f6_d_r;

  logic [3:0]              kr, ka, kl;
  logic [5:0]              kn;
  logic signed [32:0]      aa_nxt, ra_nxt, ll_nxt, nn_nxt, d_nxt;
  logic signed [16:0]      n_nxt [3];
  logic                    degen, pos;

  assign fe       = !(f6_v_r && q_full);
  assign in_stall = !fe;
  assign push     = f6_v_r && !q_full;

  always_comb begin
    kr = shamt_in(in_rel_x, in_rel_y, in_rel_z);
    ka = shamt_in(in_axis_x, in_axis_y, in_axis_z);
    kl = shamt_in(in_light_x, in_light_y, in_light_z);
    aa_nxt = f1_a_r[0] * f1_a_r[0] + f1_a_r[1] * f1_a_r[1] + f1_a_r[2] * f1_a_r[2];
    ra_nxt = f1_r_r[0] * f1_a_r[0] + f1_r_r[1] * f1_a_r[1] + f1_r_r[2] * f1_a_r[2];
    kn = shamt_nc(f4_nc_r[0], f4_nc_r[1], f4_nc_r[2]);
    for (int i = 0; i < 3; i++) begin
      unique case (f4_kind_r)
        slns_pkg::KIND_SPHERE:                   n_nxt[i] = 17'(f4_r_r[i]);
        slns_pkg::KIND_PLANE, slns_pkg::KIND_TOP: n_nxt[i] = 17'(f4_a_r[i]);
        slns_pkg::KIND_CYL:                      n_nxt[i] = 17'(red_nc(f4_nc_r[i], kn));
        default:                                 n_nxt[i] = -(17'(f4_a_r[i]));
      endcase
    end
    ll_nxt = f5_l_r[0] * f5_l_r[0] + f5_l_r[1] * f5_l_r[1] + f5_l_r[2] * f5_l_r[2];
    nn_nxt = f5_n_r[0] * f5_n_r[0] + f5_n_r[1] * f5_n_r[1] + f5_n_r[2] * f5_n_r[2];
    d_nxt  = f5_l_r[0] * f5_n_r[0] + f5_l_r[1] * f5_n_r[1] + f5_l_r[2] * f5_n_r[2];
  end

  always_comb begin
    degen = (f6_ll_r == '0) || (f6_nn_r == '0);
    pos   = !f6_d_r[32] && (f6_d_r != '0);
    push_data.ll    = f6_ll_r;
    push_data.nn    = f6_nn_r;
    push_data.dmag  = pos ? f6_d_r[31:0] : '0;
    push_data.zero  = degen || !pos;
    push_data.degen = degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
      f4_v_r <= 1'b0;
      f5_v_r <= 1'b0;
      f6_v_r <= 1'b0;
    end else if (fe) begin
      f1_v_r <= in_valid;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
      f4_v_r <= f3_v_r;
      f5_v_r <= f4_v_r;
      f6_v_r <= f5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      f1_kind_r <= in_kind;
      f1_r_r[0] <= red_in(in_rel_x, kr);
      f1_r_r[1] <= red_in(in_rel_y, kr);
      f1_r_r[2] <= red_in(in_rel_z, kr);
      f1_a_r[0] <= red_in(in_axis_x, ka);
      f1_a_r[1] <= red_in(in_axis_y, ka);
      f1_a_r[2] <= red_in(in_axis_z, ka);
      f1_l_r[0] <= red_in(in_light_x, kl);
      f1_l_r[1] <= red_in(in_light_y, kl);
      f1_l_r[2] <= red_in(in_light_z, kl);

      f2_aa_r   <= aa_nxt;
      f2_ra_r   <= ra_nxt;
      f2_kind_r <= f1_kind_r;
      f3_kind_r <= f2_kind_r;
      f4_kind_r <= f3_kind_r;
      for (int i = 0; i < 3; i++) begin
        f2_r_r[i]  <= f1_r_r[i];
        f2_a_r[i]  <= f1_a_r[i];
        f2_l_r[i]  <= f1_l_r[i];
        // cylinder side: r*(a.a) - a*(r.a)
        f3_pr_r[i] <= f2_r_r[i] * f2_aa_r;
        f3_pa_r[i] <= f2_a_r[i] * f2_ra_r;
        f3_r_r[i]  <= f2_r_r[i];
        f3_a_r[i]  <= f2_a_r[i];
        f3_l_r[i]  <= f2_l_r[i];
        f4_nc_r[i] <= f3_pr_r[i] - f3_pa_r[i];
        f4_r_r[i]  <= f3_r_r[i];
        f4_a_r[i]  <= f3_a_r[i];
        f4_l_r[i]  <= f3_l_r[i];
        f5_n_r[i]  <= n_nxt[i];
        f5_l_r[i]  <= f4_l_r[i];
      end
      f6_ll_r <= ll_nxt[31:0];
      f6_nn_r <= nn_nxt[31:0];
      f6_d_r  <= d_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/slns_fifo.sv @@
// Four-entry request queue between the front and back pipelines.
`default_nettype none
module slns_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire slns_pkg::entry_t push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  q_valid,
  output slns_pkg::entry_t      q_data
);

  slns_pkg::entry_t mem_r [4];
  logic [1:0] wptr_r, rptr_r;
  logic [2:0] cnt_r;

  assign full    = (cnt_r == 3'd4);
  assign q_valid = (cnt_r != 3'd0);
  assign q_data  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 2'd1;
      if (pop)  rptr_r <= rptr_r + 2'd1;
      if (push && !pop)      cnt_r <= cnt_r + 3'd1;
      else if (pop && !push) cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_data;
  end

endmodule
`default_nettype wire

@@ src/slns_back.sv @@
// Back pipeline: products, cos^2 restoring divide, integer square root, output register.
`default_nettype none
module slns_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire slns_pkg::entry_t q_data,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [16:0]           out_intensity,
  output logic                  out_degenerate
);

  localparam int DS = 33;  // quotient bits of 2^32*d^2 / (ll*nn)
  localparam int SS = 17;  // root bits

  logic be;

  logic        b0_v_r, b0_z_r, b0_dg_r;
  logic [63:0] b0_p_r, b0_dd_r;

  logic        dv_v_r  [DS];
  logic        dv_z_r  [DS];
  logic        dv_dg_r [DS];
  logic [63:0] dv_p_r  [DS];
  logic [63:0] dv_rem_r[DS];
  logic [32:0] dv_q_r  [DS];

  logic        sq_v_r  [SS];
  logic        sq_z_r  [SS];
  logic        sq_dg_r [SS];
  logic [32:0] sq_q_r  [SS];
  logic [16:0] sq_res_r[SS];
  logic [33:0] sq_sq_r [SS];

  logic        out_valid_r, out_degenerate_r;
  logic [16:0] out_intensity_r;

  assign be  = !out_valid_r || !out_stall;
  assign pop = be && q_valid;

  assign out_valid      = out_valid_r;
  assign out_intensity  = out_intensity_r;
  assign out_degenerate = out_degenerate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b0_v_r <= 1'b0;
    else if (be) b0_v_r <= q_valid;
  end

  always_ff @(posedge clk) begin
    if (be) begin
      b0_p_r  <= 64'(q_data.ll) * 64'(q_data.nn);
      b0_dd_r <= 64'(q_data.dmag) * 64'(q_data.dmag);
      b0_z_r  <= q_data.zero;
      b0_dg_r <= q_data.degen;
    end
  end

  for (genvar s = 0; s < DS; s++) begin : g_div
    logic        v_src, z_src, dg_src;
    logic [63:0] p_src;
    logic [64:0] rem_src;
    logic [32:0] q_src;
    logic        ge;
    logic [64:0] rem_sub;

    if (s == 0) begin : g_first
      // d^2 <= ll*nn, so the top quotient bit needs no shift
      assign v_src   = b0_v_r;
      assign z_src   = b0_z_r;
      assign dg_src  = b0_dg_r;
      assign p_src   = b0_p_r;
      assign rem_src = {1'b0, b0_dd_r};
      assign q_src   = '0;
    end else begin : g_rest
      assign v_src   = dv_v_r[s-1];
      assign z_src   = dv_z_r[s-1];
      assign dg_src  = dv_dg_r[s-1];
      assign p_src   = dv_p_r[s-1];
      assign rem_src = {dv_rem_r[s-1], 1'b0};
      assign q_src   = dv_q_r[s-1];
    end

    assign ge      = rem_src >= {1'b0, p_src};
    assign rem_sub = rem_src - {1'b0, p_src};

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[s] <= 1'b0;
      else if (be) dv_v_r[s] <= v_src;
    end

    always_ff @(posedge clk) begin
      if (be) begin
        dv_z_r[s]   <= z_src;
        dv_dg_r[s]  <= dg_src;
        dv_p_r[s]   <= p_src;
        dv_rem_r[s] <= ge ? rem_sub[63:0] : rem_src[63:0];
        dv_q_r[s]   <= {q_src[31:0], ge};
      end
    end
  end

  for (genvar t = 0; t < SS; t++) begin : g_sqrt
    localparam int B = SS - 1 - t;
    logic        v_src, z_src, dg_src;
    logic [32:0] q_src;
    logic [16:0] res_src;
    logic [33:0] sq_src;
    logic [35:0] cand_sq;
    logic        le;

    if (t == 0) begin : g_first
      assign v_src   = dv_v_r[DS-1];
      assign z_src   = dv_z_r[DS-1];
      assign dg_src  = dv_dg_r[DS-1];
      assign q_src   = dv_q_r[DS-1];
      assign res_src = '0;
      assign sq_src  = '0;
    end else begin : g_rest
      assign v_src   = sq_v_r[t-1];
      assign z_src   = sq_z_r[t-1];
      assign dg_src  = sq_dg_r[t-1];
      assign q_src   = sq_q_r[t-1];
      assign res_src = sq_res_r[t-1];
      assign sq_src  = sq_sq_r[t-1];
    end

    // (res + 2^B)^2 = res^2 + res*2^(B+1) + 2^(2B)
    assign cand_sq = 36'(sq_src) + (36'(res_src) << (B + 1)) + (36'd1 << (2 * B));
    assign le      = cand_sq <= 36'(q_src);

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[t] <= 1'b0;
      else if (be) sq_v_r[t] <= v_src;
    end

    always_ff @(posedge clk) begin
      if (be) begin
        sq_z_r[t]   <= z_src;
        sq_dg_r[t]  <= dg_src;
        sq_q_r[t]   <= q_src;
        sq_res_r[t] <= le ? (res_src | (17'd1 << B)) : res_src;
        sq_sq_r[t]  <= le ? cand_sq[33:0] : sq_src;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (be) out_valid_r <= sq_v_r[SS-1];
  end

  always_ff @(posedge clk) begin
    if (be) begin
      out_intensity_r  <= sq_z_r[SS-1] ? '0 : sq_res_r[SS-1];
      out_degenerate_r <= sq_dg_r[SS-1];
    end
  end

endmodule
`default_nettype wire

@@ src/surface_normal_lambert_shade_core.sv @@
// Throughput: one request per cycle while out_stall is low; the 33-step divide
// and 17-step root are fully pipelined, one quotient or root bit per stage.
// A four-entry queue separates the front and back pipelines.
// Reset (rst_n low, synchronous) empties all pipelines and the queue.
`default_nettype none
module surface_normal_lambert_shade_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [2:0]                     in_kind,
  input  wire logic signed [slns_pkg::CW-1:0] in_rel_x,
  input  wire logic signed [slns_pkg::CW-1:0] in_rel_y,
  input  wire logic signed [slns_pkg::CW-1:0] in_rel_z,
  input  wire logic signed [slns_pkg::CW-1:0] in_axis_x,
  input  wire logic signed [slns_pkg::CW-1:0] in_axis_y,
  input  wire logic signed [slns_pkg::CW-1:0] in_axis_z,
  input  wire logic signed [slns_pkg::CW-1:0] in_light_x,
  input  wire logic signed [slns_pkg::CW-1:0] in_light_y,
  input  wire logic signed [slns_pkg::CW-1:0] in_light_z,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [16:0]                         out_intensity,
  output logic                                out_degenerate
);

  logic             push, full, pop, q_valid;
  slns_pkg::entry_t push_data, q_data;

  slns_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_rel_x   (in_rel_x),
    .in_rel_y   (in_rel_y),
    .in_rel_z   (in_rel_z),
    .in_axis_x  (in_axis_x),
    .in_axis_y  (in_axis_y),
    .in_axis_z  (in_axis_z),
    .in_light_x (in_light_x),
    .in_light_y (in_light_y),
    .in_light_z (in_light_z),
    .push       (push),
    .push_data  (push_data),
    .q_full     (full)
  );

  slns_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  slns_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_data         (q_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_intensity  (out_intensity),
    .out_degenerate (out_degenerate)
  );

endmodule
`default_nettype wire

@@ tb/surface_normal_lambert_shade_core_test.sv @@
// Self-checking testbench for the Lambert shading core: directed and random ray hits.
`default_nettype none
module surface_normal_lambert_shade_core_test;

  typedef struct {
    logic [2:0]        kind;
    logic signed [23:0] rel [3];
    logic signed [23:0] axis [3];
    logic signed [23:0] light [3];
  } hit_t;

  typedef struct {
    logic [16:0] intensity;
    logic        degenerate;
  } shade_t;

  // floor shift of each component until all fit in 16 signed bits
  function automatic void shrink(ref longint v [3]);
    int k;
    longint s;
    bit ok;
    k = 0;
    forever begin
      ok = 1;
      for (int i = 0; i < 3; i++) begin
        s = v[i] >>> k;
        if (s < -32768 || s > 32767) ok = 0;
      end
      if (ok || k >= 62) break;
      k++;
    end
    for (int i = 0; i < 3; i++) v[i] = v[i] >>> k;
  endfunction

  function automatic shade_t lambert(hit_t h);
    shade_t res;
    longint r [3], a [3], l [3], n [3];
    longint aa, ra, d, ll, nn;
    logic [127:0] lhs, rhs, p, cand;
    logic [16:0] ival;
    for (int i = 0; i < 3; i++) begin
      r[i] = h.rel[i];
      a[i] = h.axis[i];
      l[i] = h.light[i];
    end
    shrink(r);
    shrink(a);
    shrink(l);
    case (h.kind)
      slns_pkg::KIND_SPHERE: n = r;
      slns_pkg::KIND_PLANE, slns_pkg::KIND_TOP: n = a;
      slns_pkg::KIND_CYL: begin
        aa = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
        ra = r[0]*a[0] + r[1]*a[1] + r[2]*a[2];
        for (int i = 0; i < 3; i++) n[i] = r[i]*aa - a[i]*ra;
        shrink(n);
      end
      default: for (int i = 0; i < 3; i++) n[i] = -a[i];
    endcase
    ll = l[0]*l[0] + l[1]*l[1] + l[2]*l[2];
    nn = n[0]*n[0] + n[1]*n[1] + n[2]*n[2];
    res.intensity = 0;
    res.degenerate = 0;
    if (ll == 0 || nn == 0) begin
      res.degenerate = 1;
      return res;
    end
    d = l[0]*n[0] + l[1]*n[1] + l[2]*n[2];
    if (d > 0) begin
      p = 128'(ll) * 128'(nn);
      rhs = (128'(d) * 128'(d)) << 32;
      ival = 0;
      for (int b = 16; b >= 0; b--) begin
        cand = 128'(ival | (17'd1 << b));
        lhs = cand * cand * p;
        if (lhs <= rhs) ival = cand[16:0];
      end
      if (ival > 17'd65536) ival = 17'd65536;
      res.intensity = ival;
    end
    return res;
  endfunction

  class shade_board;
    shade_t pending [$];
    int errors;

    function void note_hit(hit_t h);
      pending.push_back(lambert(h));
    endfunction

    function void check_shade(logic [16:0] inten, logic degen);
      shade_t e;
      if (pending.size() == 0) begin
        $error("unexpected result intensity=%0d degenerate=%0d", inten, degen);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (inten !== e.intensity) begin
        $error("intensity expected %0d actual %0d", e.intensity, inten);
        errors++;
      end
      if (degen !== e.degenerate) begin
        $error("degenerate expected %0d actual %0d", e.degenerate, degen);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] in_kind = 0;
  logic signed [slns_pkg::CW-1:0] in_rel_x = 0, in_rel_y = 0, in_rel_z = 0;
  logic signed [slns_pkg::CW-1:0] in_axis_x = 0, in_axis_y = 0, in_axis_z = 0;
  logic signed [slns_pkg::CW-1:0] in_light_x = 0, in_light_y = 0, in_light_z = 0;
  logic out_valid;
  logic out_stall = 1;
  logic [16:0] out_intensity;
  logic out_degenerate;

  surface_normal_lambert_shade_core dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  shade_board board = new();
  hit_t queued [$];
  bit quiet_out = 0;   // no random stalls on the output
  bit quiet_in = 0;
  bit hold_out = 0;    // long output hold-off request
  bit done_in = 0;
  int idle_cycles = 0;

  // input accepted at this edge: record its expectation; result accepted: check it
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) board.note_hit(queued.pop_front());
    if (rst_n && out_valid && !out_stall) board.check_shade(out_intensity, out_degenerate);
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 5000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1;
    else if (hold_out) out_stall <= 1;
    else if (quiet_out) out_stall <= 0;
    else out_stall <= ($urandom_range(99) < 25);
  end

  function automatic logic signed [23:0] pick_comp();
    case ($urandom_range(5))
      0: return 24'sh7fffff;
      1: return 24'sh800000;
      2: return 24'(int'($urandom_range(0, 200)) - 100);
      3: return 24'(int'($urandom_range(0, 131072)) - 65536);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic hit_t random_hit();
    hit_t h;
    int shape;
    h.kind = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
    for (int i = 0; i < 3; i++) begin
      h.rel[i] = pick_comp();
      h.axis[i] = pick_comp();
      h.light[i] = pick_comp();
    end
    shape = $urandom_range(19);
    if (shape == 0) h.axis = '{default: '0};
    if (shape == 1) h.light = '{default: '0};
    if (shape == 2) h.rel = '{default: '0};
    if (shape == 3) h.rel = h.axis;   // cylinder hit on the axis line
    return h;
  endfunction

  task automatic send(hit_t h);
    if (!quiet_in) begin
      while ($urandom_range(99) < 25) begin
        in_valid <= 0;
        @(posedge clk);
      end
    end
    queued.push_back(h);
    in_valid <= 1;
    in_kind <= h.kind;
    {in_rel_x, in_rel_y, in_rel_z} <= {h.rel[0], h.rel[1], h.rel[2]};
    {in_axis_x, in_axis_y, in_axis_z} <= {h.axis[0], h.axis[1], h.axis[2]};
    {in_light_x, in_light_y, in_light_z} <= {h.light[0], h.light[1], h.light[2]};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic directed_hit(logic [2:0] k, int r0, int r1, int r2,
                              int a0, int a1, int a2, int l0, int l1, int l2);
    hit_t h;
    h.kind = k;
    h.rel = '{24'(r0), 24'(r1), 24'(r2)};
    h.axis = '{24'(a0), 24'(a1), 24'(a2)};
    h.light = '{24'(l0), 24'(l1), 24'(l2)};
    send(h);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  localparam int MAXP = 8388607;
  localparam int MAXN = -8388608;

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    directed_hit(slns_pkg::KIND_SPHERE, 65536, 0, 0, 0, 0, 0, 65536, 0, 0);
    directed_hit(slns_pkg::KIND_SPHERE, MAXP, MAXP, MAXP, 0, 0, 0, MAXP, MAXP, MAXP);
    directed_hit(slns_pkg::KIND_SPHERE, MAXN, MAXN, MAXN, 0, 0, 0, MAXN, MAXN, MAXN);
    directed_hit(slns_pkg::KIND_SPHERE, MAXN, 0, 0, 0, 0, 0, MAXP, 0, 0);
    directed_hit(slns_pkg::KIND_SPHERE, 0, 0, 0, 1, 1, 1, 5, 5, 5);
    directed_hit(slns_pkg::KIND_PLANE, 3, 4, 5, 0, 65536, 0, 100, 200, 0);
    directed_hit(slns_pkg::KIND_PLANE, 3, 4, 5, 0, 0, 0, 100, 200, 0);
    directed_hit(slns_pkg::KIND_PLANE, 3, 4, 5, 0, 1, 0, 0, 0, 0);
    directed_hit(slns_pkg::KIND_PLANE, 0, 0, 0, 1, 0, 0, 0, 1, 0);
    directed_hit(slns_pkg::KIND_CYL, 65536, 65536, 0, 0, 65536, 0, 65536, 0, 0);
    directed_hit(slns_pkg::KIND_CYL, 0, 70000, 0, 0, 65536, 0, 65536, 0, 0);
    directed_hit(slns_pkg::KIND_CYL, MAXP, MAXN, MAXP, MAXN, MAXP, 1, 7, -9, 3);
    directed_hit(slns_pkg::KIND_CYL, 1, 2, 3, 0, 0, 0, 1, 1, 1);
    directed_hit(slns_pkg::KIND_TOP, 0, 0, 0, 0, 0, MAXP, 1, 1, MAXP);
    directed_hit(slns_pkg::KIND_BOTTOM, 0, 0, 0, 0, 0, MAXP, 1, 1, MAXN);
    directed_hit(slns_pkg::KIND_BOTTOM, 0, 0, 0, 0, 0, 65536, 0, 0, 65536);
    directed_hit(3'd5, 0, 0, 0, 0, 0, 1, 0, 0, -1);
    directed_hit(3'd6, 0, 0, 0, 1, 2, 3, -1, -2, -3);
    directed_hit(3'd7, 9, 9, 9, -1, -1, -1, 1, 1, 1);
    directed_hit(slns_pkg::KIND_SPHERE, -1, -1, -1, 0, 0, 0, -1, -1, -1);
    drain();
    // long receiver hold-off while requests keep coming; more requests than
    // the pipelines and queue can hold, so the input stalls
    hold_out = 1;
    quiet_in = 1;
    fork
      begin
        repeat (200) @(posedge clk);
        hold_out = 0;
      end
      repeat (120) send(random_hit());
    join
    quiet_in = 0;
    drain();
    for (int n = 0; n < 460; n++) begin
      quiet_out = (n >= 200 && n < 300);
      quiet_in = quiet_out;
      send(random_hit());
    end
    quiet_out = 0;
    quiet_in = 0;
    in_valid <= 0;
    done_in = 1;
  end

  initial begin
    wait (done_in);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (board.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire
